// File: design/sscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_pkg
// Types, widths, stage map and divider helpers for the segment closest-points
// pipeline.
// ----------------------------------------------------------------------------
package sscp_pkg;

   localparam int CW    = 32;          // coordinate width
   localparam int FB    = 16;          // fraction bits
   localparam int DW    = CW + 1;      // coordinate difference
   localparam int PW    = 2 * DW;      // product of two differences
   localparam int SW    = PW + 1;      // dot / cross sums
   localparam int RW    = SW + 1;      // divider remainder and divisor
   localparam int QW    = FB + 1;      // s, t in [0, 1.0]
   localparam int STEPS = FB;          // quotient bits per division
   localparam int BL    = 34;          // low slice of b for b*s
   localparam int BH    = SW - BL;
   localparam int TW    = SW + QW + 1; // t numerator
   localparam int LW    = QW + 1 + DW; // s*d product

   localparam logic [QW-1:0] UNIT_Q = {1'b1, {FB{1'b0}}};

   localparam int ST_IN    = 0;
   localparam int ST_SUM   = 3;
   localparam int ST_D1SET = ST_SUM + 1;
   localparam int ST_D1END = ST_D1SET + STEPS;
   localparam int ST_PROD  = ST_D1END + 1;
   localparam int ST_TSUM  = ST_PROD + 1;
   localparam int ST_D2SET = ST_TSUM + 1;
   localparam int ST_D2END = ST_D2SET + STEPS;
   localparam int ST_LERP  = ST_D2END + 1;
   localparam int ST_OUT   = ST_LERP + 1;
   localparam int NSTG     = ST_OUT + 1;

   typedef struct packed {
      logic signed [CW-1:0] seg1_start_x;
      logic signed [CW-1:0] seg1_start_y;
      logic signed [CW-1:0] seg1_end_x;
      logic signed [CW-1:0] seg1_end_y;
      logic signed [CW-1:0] seg2_start_x;
      logic signed [CW-1:0] seg2_start_y;
      logic signed [CW-1:0] seg2_end_x;
      logic signed [CW-1:0] seg2_end_y;
   } req_word_type;

   typedef struct packed {
      logic signed [CW-1:0] near1_x;
      logic signed [CW-1:0] near1_y;
      logic signed [CW-1:0] near2_x;
      logic signed [CW-1:0] near2_y;
   } rsp_word_type;

   typedef struct packed {
      logic signed [CW-1:0] a1x;
      logic signed [CW-1:0] a1y;
      logic signed [CW-1:0] a2x;
      logic signed [CW-1:0] a2y;
      logic signed [DW-1:0] d1x;
      logic signed [DW-1:0] d1y;
      logic signed [DW-1:0] d2x;
      logic signed [DW-1:0] d2y;
   } geom_type;

   typedef struct packed {
      geom_type             g;
      logic signed [SW-1:0] la;
      logic signed [SW-1:0] lb;
      logic signed [SW-1:0] f;
      logic signed [SW-1:0] c;
      logic signed [SW-1:0] b;
      logic signed [SW-1:0] cx;   // d1 x d2
      logic signed [SW-1:0] cy;   // d2 x r
   } sum_type;

   typedef enum logic [1:0] {DIV_ZERO, DIV_ONE, DIV_RUN} div_mode_type;

   typedef enum logic [1:0] {CASE_BOTH, CASE_FIRST, CASE_SECOND, CASE_GEN} case_type;

   typedef enum logic [2:0] {T_NEG, T_ZERO, T_ONE, T_HI, T_RUN} tcls_type;

   typedef struct packed {
      div_mode_type      mode;
      logic [RW-1:0]     rem;
      logic [RW-1:0]     dvsr;
      logic [STEPS-1:0]  feed;
      logic [STEPS-1:0]  q;
   } div_setup_type;

   // clamp(trunc(n * 2^FB / d)) to [0, 1.0]; zero divisor gives zero
   function automatic div_setup_type div_setup(input logic signed [RW-1:0] n,
                                               input logic signed [RW-1:0] d);
      div_setup_type r;
      logic [RW-1:0] nn;
      logic [RW-1:0] dd;
      nn = n[RW-1] ? RW'(-n) : RW'(n);
      dd = d[RW-1] ? RW'(-d) : RW'(d);
      r.rem  = nn;
      r.dvsr = dd;
      r.feed = '0;
      r.q    = '0;
      priority if (dd == '0) begin
         r.mode = DIV_ZERO;
      end else if (n != '0 && n[RW-1] != d[RW-1]) begin
         r.mode = DIV_ZERO;
      end else if (nn >= dd) begin
         r.mode = DIV_ONE;
      end else begin
         r.mode = DIV_RUN;
      end
      return r;
   endfunction

   function automatic div_setup_type div_step(input div_setup_type x);
      div_setup_type r;
      logic [RW:0]   sh;
      sh     = {x.rem, x.feed[STEPS-1]};
      r      = x;
      r.feed = x.feed << 1;
      if (sh >= {1'b0, x.dvsr}) begin
         r.rem = RW'(sh - {1'b0, x.dvsr});
         r.q   = {x.q[STEPS-2:0], 1'b1};
      end else begin
         r.rem = sh[RW-1:0];
         r.q   = {x.q[STEPS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [QW-1:0] div_result(input div_setup_type x);
      logic [QW-1:0] r;
      unique case (x.mode)
         DIV_ZERO: r = '0;
         DIV_ONE:  r = UNIT_Q;
         DIV_RUN:  r = {1'b0, x.q};
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: design/segment_segment_closest_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_closest_points
// Closest point on each of two 2D Q16.16 segments to the other.
//
//   channel | dir | word           | handshake
//   req     | in  | req_word_type  | req_valid / req_stall
//   rsp     | out | rsp_word_type  | rsp_valid / rsp_stall
//
// One word per cycle sustained while the output word is not held by rsp_stall.
// Two 16-stage divider chains, one bit per stage, make up most of the pipeline.
// Reset clears the stage valid bits only.
// Each stage advances when some stage at or after it is empty or the output
// word is taken, so bubbles close up under rsp_stall.
// ----------------------------------------------------------------------------
module segment_segment_closest_points
   import sscp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef struct packed {
      geom_type             g;
      case_type             cs;
      logic signed [SW-1:0] la;
      logic signed [SW-1:0] lb;
      logic signed [SW-1:0] f;
      logic signed [SW-1:0] c;
      logic signed [SW-1:0] b;
   } mid_type;

   typedef struct packed {
      mid_type                m;
      logic [QW-1:0]          s_gen;
      logic [BL+QW-1:0]       pl;
      logic signed [BH+QW:0]  ph;
   } bs_type;

   typedef struct packed {
      mid_type              m;
      logic [QW-1:0]        s_gen;
      logic signed [TW-1:0] tn;
   } tsum_type;

   typedef struct packed {
      geom_type      g;
      case_type      cs;
      tcls_type      tc;
      logic [QW-1:0] s_gen;
   } fin_type;

   typedef struct packed {
      logic signed [CW-1:0] a1x;
      logic signed [CW-1:0] a1y;
      logic signed [CW-1:0] a2x;
      logic signed [CW-1:0] a2y;
      logic signed [LW-1:0] p1x;
      logic signed [LW-1:0] p1y;
      logic signed [LW-1:0] p2x;
      logic signed [LW-1:0] p2y;
   } lerp_type;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] en;
   logic            en_out;

   sum_type       sums;
   mid_type       mid_in;
   mid_type       mid_ff [STEPS+1];
   div_setup_type div1_ff, div1_in;
   logic [QW-1:0] q1, q2, q3, q4, q5;
   bs_type        bs_ff, bs_in;
   tsum_type      tsum_ff, tsum_in;
   fin_type       fin_in;
   fin_type       fin_ff [STEPS+1];
   div_setup_type div2_ff, div3_ff, div4_ff, div5_ff;
   div_setup_type div2_in, div3_in, div4_in, div5_in;
   lerp_type      lerp_ff, lerp_in;
   rsp_word_type  rsp_ff, rsp_in;
   logic [QW-1:0] s_sel, t_sel;

   // ---- flow control
   assign en_out = !valid_ff[NSTG-1] || !rsp_stall;

   for (genvar k = 0; k < NSTG; k++) begin : g_en
      assign en[k] = en_out || !(&valid_ff[NSTG-1:k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NSTG-1];
   assign rsp_word  = rsp_ff;

   // ---- front end
   sscp_front u_front (
      .clock    (clock),
      .en       (en[ST_SUM:0]),
      .req_word (req_word),
      .sums     (sums)
   );

   // ---- case split and s division setup
   always_comb begin
      mid_in.g  = sums.g;
      mid_in.la = sums.la;
      mid_in.lb = sums.lb;
      mid_in.f  = sums.f;
      mid_in.c  = sums.c;
      mid_in.b  = sums.b;
      priority if (sums.la == '0 && sums.lb == '0) begin
         mid_in.cs = CASE_BOTH;
      end else if (sums.la == '0) begin
         mid_in.cs = CASE_FIRST;
      end else if (sums.lb == '0) begin
         mid_in.cs = CASE_SECOND;
      end else begin
         mid_in.cs = CASE_GEN;
      end
      // s = (b*f - c*lb) / den reduces to (d2 x r) / (d1 x d2)
      div1_in = div_setup(RW'(sums.cy), RW'(sums.cx));
   end

   sscp_div_lane u_div1 (
      .clock (clock),
      .en    (en[ST_D1END:ST_D1SET+1]),
      .setup (div1_ff),
      .quo   (q1)
   );

   // ---- t numerator: b*s + f*2^FB
   always_comb begin
      bs_in.m     = mid_ff[STEPS];
      bs_in.s_gen = q1;
      bs_in.pl    = mid_ff[STEPS].b[BL-1:0] * q1;
      bs_in.ph    = $signed(mid_ff[STEPS].b[SW-1:BL]) * $signed({1'b0, q1});
   end

   always_comb begin
      tsum_in.m     = bs_ff.m;
      tsum_in.s_gen = bs_ff.s_gen;
      tsum_in.tn    = (TW'(bs_ff.ph) <<< BL) + $signed(TW'(bs_ff.pl))
                    + (TW'(bs_ff.m.f) <<< FB);
   end

   // ---- t classification and second division setup
   always_comb begin
      logic signed [TW-1:0] lb_t;
      logic signed [TW-1:0] lb16;
      logic signed [TW-1:0] lb17;
      logic signed [TW-1:0] neg_t;
      lb_t  = TW'(tsum_ff.m.lb);
      lb16  = lb_t <<< FB;
      lb17  = lb16 + lb_t;
      neg_t = -tsum_ff.tn;

      fin_in.g     = tsum_ff.m.g;
      fin_in.cs    = tsum_ff.m.cs;
      fin_in.s_gen = tsum_ff.s_gen;
      priority if (tsum_ff.tn[TW-1]) begin
         fin_in.tc = (neg_t >= lb_t) ? T_NEG : T_ZERO;
      end else if (tsum_ff.tn >= lb17) begin
         fin_in.tc = T_HI;
      end else if (tsum_ff.tn >= lb16) begin
         fin_in.tc = T_ONE;
      end else begin
         fin_in.tc = T_RUN;
      end

      div2_in = div_setup(-RW'(tsum_ff.m.c), RW'(tsum_ff.m.la));
      div3_in = div_setup(RW'(tsum_ff.m.b) - RW'(tsum_ff.m.c), RW'(tsum_ff.m.la));
      div4_in = div_setup(RW'(tsum_ff.m.f), RW'(tsum_ff.m.lb));

      div5_in.mode = DIV_RUN;
      div5_in.rem  = RW'(tsum_ff.tn[TW-1:FB]);
      div5_in.dvsr = RW'(tsum_ff.m.lb);
      div5_in.feed = tsum_ff.tn[FB-1:0];
      div5_in.q    = '0;
   end

   sscp_div_lane u_div2 (
      .clock (clock), .en (en[ST_D2END:ST_D2SET+1]), .setup (div2_ff), .quo (q2)
   );
   sscp_div_lane u_div3 (
      .clock (clock), .en (en[ST_D2END:ST_D2SET+1]), .setup (div3_ff), .quo (q3)
   );
   sscp_div_lane u_div4 (
      .clock (clock), .en (en[ST_D2END:ST_D2SET+1]), .setup (div4_ff), .quo (q4)
   );
   sscp_div_lane u_div5 (
      .clock (clock), .en (en[ST_D2END:ST_D2SET+1]), .setup (div5_ff), .quo (q5)
   );

   // ---- pick s, t and scale the directions
   always_comb begin
      unique case (fin_ff[STEPS].cs)
         CASE_BOTH: begin
            s_sel = '0;
            t_sel = '0;
         end
         CASE_FIRST: begin
            s_sel = '0;
            t_sel = q4;
         end
         CASE_SECOND: begin
            s_sel = q2;
            t_sel = '0;
         end
         CASE_GEN: begin
            unique case (fin_ff[STEPS].tc)
               T_NEG: begin
                  s_sel = q2;
                  t_sel = '0;
               end
               T_ZERO: begin
                  s_sel = fin_ff[STEPS].s_gen;
                  t_sel = '0;
               end
               T_ONE: begin
                  s_sel = fin_ff[STEPS].s_gen;
                  t_sel = UNIT_Q;
               end
               T_HI: begin
                  s_sel = q3;
                  t_sel = UNIT_Q;
               end
               T_RUN: begin
                  s_sel = fin_ff[STEPS].s_gen;
                  t_sel = q5;
               end
               default: begin
                  s_sel = '0;
                  t_sel = '0;
               end
            endcase
         end
         default: begin
            s_sel = '0;
            t_sel = '0;
         end
      endcase

      lerp_in.a1x = fin_ff[STEPS].g.a1x;
      lerp_in.a1y = fin_ff[STEPS].g.a1y;
      lerp_in.a2x = fin_ff[STEPS].g.a2x;
      lerp_in.a2y = fin_ff[STEPS].g.a2y;
      lerp_in.p1x = $signed({1'b0, s_sel}) * fin_ff[STEPS].g.d1x;
      lerp_in.p1y = $signed({1'b0, s_sel}) * fin_ff[STEPS].g.d1y;
      lerp_in.p2x = $signed({1'b0, t_sel}) * fin_ff[STEPS].g.d2x;
      lerp_in.p2y = $signed({1'b0, t_sel}) * fin_ff[STEPS].g.d2y;
   end

   always_comb begin
      logic signed [LW-1:0] s1x, s1y, s2x, s2y;
      s1x = lerp_ff.p1x >>> FB;
      s1y = lerp_ff.p1y >>> FB;
      s2x = lerp_ff.p2x >>> FB;
      s2y = lerp_ff.p2y >>> FB;
      rsp_in.near1_x = lerp_ff.a1x + s1x[CW-1:0];
      rsp_in.near1_y = lerp_ff.a1y + s1y[CW-1:0];
      rsp_in.near2_x = lerp_ff.a2x + s2x[CW-1:0];
      rsp_in.near2_y = lerp_ff.a2y + s2y[CW-1:0];
   end

   // ---- datapath registers
   always_ff @(posedge clock) begin
      if (en[ST_D1SET]) begin
         mid_ff[0] <= mid_in;
         div1_ff   <= div1_in;
      end
      for (int k = 1; k <= STEPS; k++) begin
         if (en[ST_D1SET+k]) begin
            mid_ff[k] <= mid_ff[k-1];
         end
      end
      if (en[ST_PROD]) begin
         bs_ff <= bs_in;
      end
      if (en[ST_TSUM]) begin
         tsum_ff <= tsum_in;
      end
      if (en[ST_D2SET]) begin
         fin_ff[0] <= fin_in;
         div2_ff   <= div2_in;
         div3_ff   <= div3_in;
         div4_ff   <= div4_in;
         div5_ff   <= div5_in;
      end
      for (int k = 1; k <= STEPS; k++) begin
         if (en[ST_D2SET+k]) begin
            fin_ff[k] <= fin_ff[k-1];
         end
      end
      if (en[ST_LERP]) begin
         lerp_ff <= lerp_in;
      end
      if (en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: design/sscp_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_div_lane
// Restoring divider, one quotient bit per pipeline stage, clamped result.
// ----------------------------------------------------------------------------
module sscp_div_lane
   import sscp_pkg::*;
(
   input  logic          clock,
   input  logic [STEPS-1:0] en,
   input  div_setup_type setup,
   output logic [QW-1:0] quo
);

   div_setup_type stg_ff [STEPS];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         stg_ff[0] <= div_step(setup);
      end
      for (int k = 1; k < STEPS; k++) begin
         if (en[k]) begin
            stg_ff[k] <= div_step(stg_ff[k-1]);
         end
      end
   end

   assign quo = div_result(stg_ff[STEPS-1]);

endmodule

// File: design/sscp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_front
// Input register, coordinate differences, products and dot/cross sums.
// ----------------------------------------------------------------------------
module sscp_front
   import sscp_pkg::*;
(
   input  logic            clock,
   input  logic [ST_SUM:0] en,
   input  req_word_type    req_word,
   output sum_type         sums
);

   typedef struct packed {
      geom_type             g;
      logic signed [DW-1:0] rx;
      logic signed [DW-1:0] ry;
   } diff_type;

   typedef struct packed {
      geom_type             g;
      logic signed [PW-1:0] d1x_d1x;
      logic signed [PW-1:0] d1y_d1y;
      logic signed [PW-1:0] d2x_d2x;
      logic signed [PW-1:0] d2y_d2y;
      logic signed [PW-1:0] d2x_rx;
      logic signed [PW-1:0] d2y_ry;
      logic signed [PW-1:0] d1x_rx;
      logic signed [PW-1:0] d1y_ry;
      logic signed [PW-1:0] d1x_d2x;
      logic signed [PW-1:0] d1y_d2y;
      logic signed [PW-1:0] d1x_d2y;
      logic signed [PW-1:0] d1y_d2x;
      logic signed [PW-1:0] d2x_ry;
      logic signed [PW-1:0] d2y_rx;
   } prod_type;

   req_word_type in_ff;
   diff_type     diff_ff, diff_in;
   prod_type     prod_ff, prod_in;
   sum_type      sum_ff, sum_in;

   always_comb begin
      diff_in.g.a1x = in_ff.seg1_start_x;
      diff_in.g.a1y = in_ff.seg1_start_y;
      diff_in.g.a2x = in_ff.seg2_start_x;
      diff_in.g.a2y = in_ff.seg2_start_y;
      diff_in.g.d1x = DW'(in_ff.seg1_end_x) - DW'(in_ff.seg1_start_x);
      diff_in.g.d1y = DW'(in_ff.seg1_end_y) - DW'(in_ff.seg1_start_y);
      diff_in.g.d2x = DW'(in_ff.seg2_end_x) - DW'(in_ff.seg2_start_x);
      diff_in.g.d2y = DW'(in_ff.seg2_end_y) - DW'(in_ff.seg2_start_y);
      diff_in.rx    = DW'(in_ff.seg1_start_x) - DW'(in_ff.seg2_start_x);
      diff_in.ry    = DW'(in_ff.seg1_start_y) - DW'(in_ff.seg2_start_y);
   end

   always_comb begin
      prod_in.g       = diff_ff.g;
      prod_in.d1x_d1x = diff_ff.g.d1x * diff_ff.g.d1x;
      prod_in.d1y_d1y = diff_ff.g.d1y * diff_ff.g.d1y;
      prod_in.d2x_d2x = diff_ff.g.d2x * diff_ff.g.d2x;
      prod_in.d2y_d2y = diff_ff.g.d2y * diff_ff.g.d2y;
      prod_in.d2x_rx  = diff_ff.g.d2x * diff_ff.rx;
      prod_in.d2y_ry  = diff_ff.g.d2y * diff_ff.ry;
      prod_in.d1x_rx  = diff_ff.g.d1x * diff_ff.rx;
      prod_in.d1y_ry  = diff_ff.g.d1y * diff_ff.ry;
      prod_in.d1x_d2x = diff_ff.g.d1x * diff_ff.g.d2x;
      prod_in.d1y_d2y = diff_ff.g.d1y * diff_ff.g.d2y;
      prod_in.d1x_d2y = diff_ff.g.d1x * diff_ff.g.d2y;
      prod_in.d1y_d2x = diff_ff.g.d1y * diff_ff.g.d2x;
      prod_in.d2x_ry  = diff_ff.g.d2x * diff_ff.ry;
      prod_in.d2y_rx  = diff_ff.g.d2y * diff_ff.rx;
   end

   always_comb begin
      sum_in.g  = prod_ff.g;
      sum_in.la = SW'(prod_ff.d1x_d1x) + SW'(prod_ff.d1y_d1y);
      sum_in.lb = SW'(prod_ff.d2x_d2x) + SW'(prod_ff.d2y_d2y);
      sum_in.f  = SW'(prod_ff.d2x_rx) + SW'(prod_ff.d2y_ry);
      sum_in.c  = SW'(prod_ff.d1x_rx) + SW'(prod_ff.d1y_ry);
      sum_in.b  = SW'(prod_ff.d1x_d2x) + SW'(prod_ff.d1y_d2y);
      sum_in.cx = SW'(prod_ff.d1x_d2y) - SW'(prod_ff.d1y_d2x);
      sum_in.cy = SW'(prod_ff.d2x_ry) - SW'(prod_ff.d2y_rx);
   end

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         in_ff <= req_word;
      end
      if (en[ST_IN+1]) begin
         diff_ff <= diff_in;
      end
      if (en[ST_IN+2]) begin
         prod_ff <= prod_in;
      end
      if (en[ST_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   assign sums = sum_ff;

endmodule

// File: design/sscp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_checker
// Port-level checks for the segment closest-points pipeline.
// ----------------------------------------------------------------------------
module sscp_checker
   import sscp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // input side only backs up when every stage is full and the word is held
   a_stall_source: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without held output word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled rsp word changed");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && req_valid) |=> req_stall || !rsp_stall ||
                                               rsp_valid)
      else $error("rsp word lost under stall");

endmodule

bind segment_segment_closest_points sscp_checker u_sscp_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_segment_closest_points. A driver sends words
// from a queue in random bursts. A scoreboard computes the closest points of
// each accepted word with wide integer math and compares every output word
// as a whole against the oldest expected word. The output channel is
// stalled in several patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import sscp_pkg::*;

   typedef logic signed [255:0] wide_type;
   localparam wide_type UNIT = wide_type'(1) <<< FB;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   req_word_type pend_q[$];
   bit           drain_q[$];
   rsp_word_type near_q[$];
   bit           req_took;
   int           gap_left;
   int           burst_left;
   int           mism_count;
   int           stall_mode;
   int           cyc;
   bit           stim_done;

   segment_segment_closest_points u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // trunc(num * 1.0 / den) clamped to [0, 1.0]; zero den gives zero
   function automatic wide_type unit_quot(input wide_type num, input wide_type den);
      wide_type q;
      if (den == 0) begin
         return 0;
      end
      q = (num * UNIT) / den;
      if (q < 0) begin
         q = 0;
      end else if (q > UNIT) begin
         q = UNIT;
      end
      return q;
   endfunction

   function automatic logic signed [CW-1:0] along(input wide_type a, input wide_type d,
                                                  input wide_type s);
      wide_type p;
      p = (s * d) >>> FB;
      return CW'(a + p);
   endfunction

   function automatic rsp_word_type closest_points(input req_word_type w);
      rsp_word_type r;
      wide_type a1x, a1y, a2x, a2y, d1x, d1y, d2x, d2y, rx, ry;
      wide_type la, lb, f, c, b, den, s, t, tq;
      a1x = w.seg1_start_x;
      a1y = w.seg1_start_y;
      a2x = w.seg2_start_x;
      a2y = w.seg2_start_y;
      d1x = wide_type'(w.seg1_end_x) - a1x;
      d1y = wide_type'(w.seg1_end_y) - a1y;
      d2x = wide_type'(w.seg2_end_x) - a2x;
      d2y = wide_type'(w.seg2_end_y) - a2y;
      rx  = a1x - a2x;
      ry  = a1y - a2y;
      la  = d1x * d1x + d1y * d1y;
      lb  = d2x * d2x + d2y * d2y;
      f   = d2x * rx + d2y * ry;
      c   = d1x * rx + d1y * ry;
      b   = d1x * d2x + d1y * d2y;
      s   = 0;
      t   = 0;
      if (la == 0 && lb == 0) begin
         s = 0;
      end else if (la == 0) begin
         t = unit_quot(f, lb);
      end else if (lb == 0) begin
         s = unit_quot(-c, la);
      end else begin
         den = la * lb - b * b;
         s   = (den == 0) ? 0 : unit_quot(b * f - c * lb, den);
         tq  = (b * s + f * UNIT) / lb;
         if (tq < 0) begin
            t = 0;
            s = unit_quot(-c, la);
         end else if (tq > UNIT) begin
            t = UNIT;
            s = unit_quot(b - c, la);
         end else begin
            t = tq;
         end
      end
      r.near1_x = along(a1x, d1x, s);
      r.near1_y = along(a1y, d1y, s);
      r.near2_x = along(a2x, d2x, t);
      r.near2_y = along(a2y, d2y, t);
      return r;
   endfunction

   function automatic req_word_type pair(input int ax, input int ay, input int bx,
                                         input int by, input int cx, input int cy,
                                         input int dx, input int dy);
      req_word_type w;
      w = {ax, ay, bx, by, cx, cy, dx, dy};
      return w;
   endfunction

   function automatic int small_coord();
      return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
   endfunction

   function automatic req_word_type random_pair();
      req_word_type w;
      int kind;
      int k;
      kind = $urandom_range(0, 9);
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (kind >= 3) begin
         w = pair(small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), small_coord(), small_coord());
      end
      case (kind)
         6: begin
            w.seg1_end_x = w.seg1_start_x;
            w.seg1_end_y = w.seg1_start_y;
         end
         7: begin
            w.seg2_end_x = w.seg2_start_x;
            w.seg2_end_y = w.seg2_start_y;
         end
         8: begin
            k = int'($urandom_range(0, 6)) - 3;
            w.seg2_end_x = w.seg2_start_x + k * (w.seg1_end_x - w.seg1_start_x);
            w.seg2_end_y = w.seg2_start_y + k * (w.seg1_end_y - w.seg1_start_y);
         end
         9: begin
            w.seg1_end_x = w.seg1_start_x;
            w.seg1_end_y = w.seg1_start_y;
            if ($urandom_range(0, 1) == 1) begin
               w.seg2_end_x = w.seg2_start_x;
               w.seg2_end_y = w.seg2_start_y;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      int i;
      int mx;
      int mn;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      pend_q.push_back(pair(0, 0, 0, 0, 0, 0, 0, 0));
      pend_q.push_back(pair(5 << 16, 7 << 16, 5 << 16, 7 << 16, -3, 9, -3, 9));
      pend_q.push_back(pair(1 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0, 4 << 16, 0));
      pend_q.push_back(pair(0, 0, 4 << 16, 0, 2 << 16, 3 << 16, 2 << 16, 3 << 16));
      pend_q.push_back(pair(0, 0, 4 << 16, 0, 0, 1 << 16, 4 << 16, 1 << 16));
      pend_q.push_back(pair(0, 0, 4 << 16, 0, 6 << 16, 1 << 16, 9 << 16, 1 << 16));
      pend_q.push_back(pair(0, 0, 4 << 16, 4 << 16, 0, 4 << 16, 4 << 16, 0));
      pend_q.push_back(pair(0, 0, 1 << 16, 0, 5 << 16, 1 << 16, 5 << 16, 9 << 16));
      pend_q.push_back(pair(0, 0, 1 << 16, 0, -5 << 16, 9 << 16, -5 << 16, 1 << 16));
      pend_q.push_back(pair(0, 0, 8 << 16, 0, 2 << 16, 1 << 16, 3 << 16, 5 << 16));
      pend_q.push_back(pair(0, 0, 8 << 16, 0, 3 << 16, 5 << 16, 2 << 16, 1 << 16));
      pend_q.push_back(pair(mn, mn, mx, mx, mx, mn, mn, mx));
      pend_q.push_back(pair(mx, mx, mn, mn, mn, mn, mx, mx));
      pend_q.push_back(pair(mn, mn, mn, mn, mx, mx, mx, mx));
      pend_q.push_back(pair(mn, mx, mn, mx, mx, mn, mn, mn));
      pend_q.push_back(pair(mx, mn, mn, mx, 0, 0, mx, mx));
      pend_q.push_back(pair(-1, -1, 1, 1, -1, 1, 1, -1));
      pend_q.push_back(pair(0, 0, 3, 0, 1, 0, 2, 0));
      pend_q.push_back(pair(0, 0, 3, 0, 4, 0, 7, 0));
      pend_q.push_back(pair(-1, -1, -1, -1, -1, -1, -1, -1));
      for (i = 0; i < pend_q.size(); i++) begin
         drain_q.push_back(1'b0);
      end
      for (i = 0; i < 600; i++) begin
         pend_q.push_back(random_pair());
         drain_q.push_back(i == 0 || i == 300);
      end
   end

   always @(negedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_valid  <= 1'b0;
         req_word   <= '0;
         gap_left   <= 0;
         burst_left <= $urandom_range(1, 20);
      end else if (req_valid && !req_took) begin
      end else begin
         req_took = 1'b0;
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pend_q.size() == 0) begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end else if (drain_q[0] && near_q.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            req_word  <= pend_q.pop_front();
            void'(drain_q.pop_front());
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver stall pattern, one of four modes, is redrawn at random from the cyc counter
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if (cyc % 128 == 0) begin
            stall_mode <= $urandom_range(0, 3);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= (cyc % 5 < 2);
            default: rsp_stall <= (cyc % 64 < 24);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            near_q.push_back(closest_points(req_word));
            req_took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (near_q.size() == 0) begin
               mism_count++;
               if (mism_count <= 10) begin
                  $display("unexpected word %h", rsp_word);
               end
            end else begin
               want = near_q.pop_front();
               if (want !== rsp_word) begin
                  mism_count++;
                  if (mism_count <= 10) begin
                     $display("near1 exp %h %h got %h %h", want.near1_x, want.near1_y,
                              rsp_word.near1_x, rsp_word.near1_y);
                     $display("near2 exp %h %h got %h %h", want.near2_x, want.near2_y,
                              rsp_word.near2_x, rsp_word.near2_y);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      rsp_stall  = 1'b0;
      req_valid  = 1'b0;
      req_word   = '0;
      req_took   = 1'b0;
      stim_done  = 1'b0;
      cyc        = 0;
      mism_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      wait (near_q.size() == 0);
      repeat (60) @(posedge clock);
      if (mism_count == 0 && near_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: segment_segment_closest_points.f
design/sscp_pkg.sv
design/sscp_div_lane.sv
design/sscp_front.sv
design/segment_segment_closest_points.sv
design/sscp_checker.sv
tb/tb_top.sv
